>>> rtl/sact_pkg.sv
// ----------------------------------------------------------------------------
// sact_pkg: shared types and constants
// Geometry limits, configuration, item, result and tag-row types.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int Sets        = 256;
  localparam int Ways        = 8;
  localparam int IdxW        = $clog2(Sets);
  localparam int WayW        = $clog2(Ways);
  localparam int RankW       = 3;
  localparam int TagW        = 30;
  localparam int FillW       = 17;
  localparam int CycW        = 18;
  localparam int TotW        = 48;
  localparam int CntW        = 32;
  localparam int SetsLog2Max = 8;
  localparam int BlkLog2Max  = 12;
  localparam int BlkLog2Min  = 2;
  localparam int WordCost    = 100;

  typedef enum logic [2:0] {
    REG_SETS_LOG2   = 3'd0,
    REG_WAYS_LOG2   = 3'd1,
    REG_BLOCK_LOG2  = 3'd2,
    REG_WRITE_ALLOC = 3'd3,
    REG_WRITE_THRU  = 3'd4,
    REG_USE_LRU     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [3:0] sets_log2;
    logic [1:0] ways_log2;
    logic [3:0] block_bytes_log2;
    logic       write_allocate;
    logic       write_through;
    logic       use_lru;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic            hit;
    logic            filled;
    logic            dirty_evicted;
    logic [CycW-1:0] cycles_added;
    logic [CntW-1:0] n_loads;
    logic [CntW-1:0] n_stores;
    logic [CntW-1:0] n_ld_hits;
    logic [CntW-1:0] n_st_hits;
    logic [TotW-1:0] cyc_total;
  } res_t;

  // classified access handed from front to back
  typedef struct packed {
    logic             mode;
    logic [IdxW-1:0]  idx;
    logic [TagW-1:0]  tag;
    logic [FillW-1:0] fill_cost;
    logic [1:0]       ways_log2;
  } item_t;

  typedef struct packed {
    logic             vld;
    logic             dirty;
    logic [RankW-1:0] rank;
    logic [TagW-1:0]  tag;
  } way_t;

  typedef way_t [Ways-1:0] row_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/set_assoc_cache_tag_model_top.sv
// An item taken into an empty block passes the item queue, the back end's EXEC
//   state and the done_o register; done_o is held for one cycle.
// The back end reads then writes one set row in the single-port tag memory
//   per item and takes no new item until it has written the last one back.
// busy is high only while the 2-entry item queue is full; results cannot stall.
// Reset sets default config, clears counters and all per-set row valids at once.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_model_top: set-associative cache tag model
// Front classifier, item queue and set update engine with LRU/FIFO ranks.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_model_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  sact_pkg::in_t  in_i,
  output logic           done_o,
  output sact_pkg::res_t res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [2:0]     cfg_index_i,
  input  logic [3:0]     cfg_data_i
);

  sact_pkg::cfg_t    cfg_q;
  sact_pkg::item_t   fr_item, head;
  sact_pkg::q_stat_t q_stat;
  logic push, pop, cfg_we, geo_clear;

  // config writes are registered; geometry writes also drop all row valids
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign geo_clear   = cfg_we &
    ((cfg_index_i == sact_pkg::REG_SETS_LOG2) ||
     (cfg_index_i == sact_pkg::REG_WAYS_LOG2) ||
     (cfg_index_i == sact_pkg::REG_BLOCK_LOG2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sets_log2        <= 4'd0;
      cfg_q.ways_log2        <= 2'd0;
      cfg_q.block_bytes_log2 <= 4'd4;
      cfg_q.write_allocate   <= 1'b1;
      cfg_q.write_through    <= 1'b0;
      cfg_q.use_lru          <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index_i)
        sact_pkg::REG_SETS_LOG2:   cfg_q.sets_log2        <= cfg_data_i;
        sact_pkg::REG_WAYS_LOG2:   cfg_q.ways_log2        <= cfg_data_i[1:0];
        sact_pkg::REG_BLOCK_LOG2:  cfg_q.block_bytes_log2 <= cfg_data_i;
        sact_pkg::REG_WRITE_ALLOC: cfg_q.write_allocate   <= cfg_data_i[0];
        sact_pkg::REG_WRITE_THRU:  cfg_q.write_through    <= cfg_data_i[0];
        sact_pkg::REG_USE_LRU:     cfg_q.use_lru          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign busy = q_stat.full;

  sact_front u_front (
    .start_i  (start),
    .in_i     (in_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .item_o   (fr_item)
  );

  sact_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (fr_item),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  sact_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .clear_i  (geo_clear),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .done_o   (done_o),
    .res_o    (res_o)
  );

  // the engine returns to idle after each item, so strobes never touch
  a_no_adjacent_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("back-to-back result strobes");

  // a hit never fills; a dirty eviction only comes with a fill
  a_hit_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.hit && res_o.filled)) else $error("hit with fill");

  a_evict_needs_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.dirty_evicted) |-> res_o.filled) else $error("evict w/o fill");

  // every access adds a nonzero cost
  a_cost_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.cycles_added != '0)) else $error("zero access cost");

endmodule

>>> rtl/sact_front.sv
// ----------------------------------------------------------------------------
// sact_front: access classifier
// Clamps geometry, splits the address into set index and tag, prices a fill.
// ----------------------------------------------------------------------------
module sact_front (
  input  logic          start_i,
  input  sact_pkg::in_t in_i,
  input  sact_pkg::cfg_t cfg_i,
  input  logic          q_full_i,
  output logic          push_o,
  output sact_pkg::item_t item_o
);

  logic [3:0]  s, b, bm2;
  logic [4:0]  sh;
  logic [31:0] a_idx, a_tag;
  logic [8:0]  m9;

  always_comb begin
    s   = (cfg_i.sets_log2 > 4'(sact_pkg::SetsLog2Max)) ?
          4'(sact_pkg::SetsLog2Max) : cfg_i.sets_log2;
    b   = cfg_i.block_bytes_log2;
    if (b > 4'(sact_pkg::BlkLog2Max)) b = 4'(sact_pkg::BlkLog2Max);
    if (b < 4'(sact_pkg::BlkLog2Min)) b = 4'(sact_pkg::BlkLog2Min);
    bm2 = b - 4'(sact_pkg::BlkLog2Min);
    sh  = 5'(b) + 5'(s);
    a_idx = in_i.address >> b;
    a_tag = in_i.address >> sh;
    m9    = (9'd1 << s) - 9'd1;
    item_o.mode      = in_i.mode;
    item_o.idx       = a_idx[sact_pkg::IdxW-1:0] & m9[sact_pkg::IdxW-1:0];
    item_o.tag       = a_tag[sact_pkg::TagW-1:0];
    item_o.fill_cost = sact_pkg::FillW'(sact_pkg::WordCost) << bm2;
    item_o.ways_log2 = cfg_i.ways_log2;
  end

  assign push_o = start_i & ~q_full_i;

endmodule

>>> rtl/sact_fifo.sv
// ----------------------------------------------------------------------------
// sact_fifo: two-entry item queue
// Decouples the classifier from the set read/update engine.
// ----------------------------------------------------------------------------
module sact_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sact_pkg::item_t   item_i,
  input  logic              pop_i,
  output sact_pkg::item_t   head_o,
  output sact_pkg::q_stat_t stat_o
);

  sact_pkg::item_t mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wp_d  = wp_q ^ push_i;
    rp_d  = rp_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

  assign head_o       = mem_q[rp_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

endmodule

>>> rtl/sact_back.sv
// ----------------------------------------------------------------------------
// sact_back: set read/update engine
// Reads one set row, resolves hit, fill and eviction, writes the row back.
// ----------------------------------------------------------------------------
module sact_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sact_pkg::cfg_t    cfg_i,
  input  logic              clear_i,
  input  sact_pkg::item_t   head_i,
  input  sact_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  output logic              done_o,
  output sact_pkg::res_t    res_o
);

  typedef enum logic {S_IDLE, S_EXEC} state_e;

  localparam int W = sact_pkg::Ways;

  state_e state_q;
  sact_pkg::row_t mem [sact_pkg::Sets];
  sact_pkg::row_t rd_q, row, nrow;
  logic [sact_pkg::Sets-1:0] rvld_q;
  logic rv_q;
  sact_pkg::item_t cur_q;
  logic done_q;
  sact_pkg::res_t res_q;
  logic [sact_pkg::CntW-1:0] ld_q, st_q, ldh_q, sth_q;
  logic [sact_pkg::TotW-1:0] tot_q;

  logic [W-1:0] inuse, vld;
  logic [3:0] nways, n;
  logic hit, full, alloc, devict, hfound, vfound, store, mkdirty;
  logic [sact_pkg::WayW-1:0] way, hway, vway;
  logic [sact_pkg::RankW-1:0] r, newrank;
  logic [sact_pkg::CycW-1:0] cost;
  logic [sact_pkg::TotW:0] tsum;

  assign pop_o = (state_q == S_IDLE) & ~q_stat_i.empty;

  always_comb begin
    row   = rv_q ? rd_q : '0;
    nways = 4'd1 << cur_q.ways_log2;
    store = cur_q.mode;
    n = '0; hit = 1'b0; hfound = 1'b0; vfound = 1'b0;
    hway = '0; vway = '0;
    for (int j = 0; j < W; j++) begin
      inuse[j] = 4'(j) < nways;
      vld[j]   = row[j].vld & inuse[j];
      n = n + 4'(vld[j]);
      if (!hfound && vld[j] && row[j].tag == cur_q.tag) begin
        hfound = 1'b1;
        hway   = sact_pkg::WayW'(j);
      end
    end
    hit  = hfound;
    full = n >= nways;
    for (int j = 0; j < W; j++) begin
      if (!vfound && full && vld[j] && row[j].rank == '0) begin
        vfound = 1'b1; vway = sact_pkg::WayW'(j);
      end else if (!vfound && !full && inuse[j] && !vld[j]) begin
        vfound = 1'b1; vway = sact_pkg::WayW'(j);
      end
    end
    alloc  = ~hit & (~store | cfg_i.write_allocate);
    way    = hit ? hway : vway;
    r      = hit ? row[hway].rank : '0;
    devict = alloc & full & row[vway].dirty;
    mkdirty = store & cfg_i.write_allocate & ~cfg_i.write_through;
    newrank = hit ? sact_pkg::RankW'(n - 4'd1) :
              (full ? sact_pkg::RankW'(nways - 4'd1) : sact_pkg::RankW'(n));
    nrow = row;
    for (int j = 0; j < W; j++) begin
      if (((hit && cfg_i.use_lru) || (alloc && full)) &&
          sact_pkg::WayW'(j) != way && vld[j] && row[j].rank > r) begin
        nrow[j].rank = row[j].rank - 1'b1;
      end
    end
    if ((hit && cfg_i.use_lru) || alloc) nrow[way].rank = newrank;
    if (alloc) begin
      nrow[way].tag   = cur_q.tag;
      nrow[way].vld   = 1'b1;
      nrow[way].dirty = 1'b0;
    end
    if (mkdirty) nrow[way].dirty = 1'b1;
    // worst case 1 + 2 * 102400 + 100 stays below 2^18
    cost = sact_pkg::CycW'(1)
         + (alloc  ? sact_pkg::CycW'(cur_q.fill_cost) : '0)
         + (devict ? sact_pkg::CycW'(cur_q.fill_cost) : '0)
         + ((store && cfg_i.write_through) ?
            sact_pkg::CycW'(sact_pkg::WordCost) : '0);
    tsum = {1'b0, tot_q} + (sact_pkg::TotW+1)'(cost);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) rd_q <= mem[head_i.idx];
    if (state_q == S_EXEC) mem[cur_q.idx] <= nrow;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rvld_q  <= '0;
      rv_q    <= 1'b0;
      done_q  <= 1'b0;
      res_q   <= '0;
      ld_q    <= '0;
      st_q    <= '0;
      ldh_q   <= '0;
      sth_q   <= '0;
      tot_q   <= '0;
    end else begin
      done_q <= (state_q == S_EXEC);
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            rv_q    <= rvld_q[head_i.idx];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          res_q.hit           <= hit;
          res_q.filled        <= alloc;
          res_q.dirty_evicted <= devict;
          res_q.cycles_added  <= cost;
          res_q.n_loads       <= (!store && ~&ld_q) ? ld_q + 1'b1 : ld_q;
          res_q.n_stores      <= (store && ~&st_q) ? st_q + 1'b1 : st_q;
          res_q.n_ld_hits     <= (!store && hit && ~&ldh_q) ? ldh_q + 1'b1 : ldh_q;
          res_q.n_st_hits     <= (store && hit && ~&sth_q) ? sth_q + 1'b1 : sth_q;
          res_q.cyc_total     <= tsum[sact_pkg::TotW] ? '1 : tsum[sact_pkg::TotW-1:0];
          if (!store && ~&ld_q) ld_q <= ld_q + 1'b1;
          if (store && ~&st_q) st_q <= st_q + 1'b1;
          if (!store && hit && ~&ldh_q) ldh_q <= ldh_q + 1'b1;
          if (store && hit && ~&sth_q) sth_q <= sth_q + 1'b1;
          tot_q <= tsum[sact_pkg::TotW] ? '1 : tsum[sact_pkg::TotW-1:0];
        end
        default: state_q <= S_IDLE;
      endcase
      if (clear_i) rvld_q <= '0;
      else if (state_q == S_EXEC) rvld_q[cur_q.idx] <= 1'b1;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
